/* hdl/fpa_pkg.sv */
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int FracBitsDef = 8;
  localparam int WordBitsDef = 32;
  localparam int ActBits     = 4;

  typedef enum logic [ActBits-1:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_EQ       = 4'd4,
    ACT_NE       = 4'd5,
    ACT_GE       = 4'd6,
    ACT_LE       = 4'd7,
    ACT_GT       = 4'd8,
    ACT_LT       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_TO_INT   = 4'd14,
    ACT_FROM_INT = 4'd15
  } action_e;

  // control that travels alongside each request
  typedef struct packed {
    logic    valid;
    action_e act;
    logic    neg;
    logic    truth;
    logic    dz;
  } ctrl_t;

endpackage

/* hdl/fpa_pre.sv */
`timescale 1ns / 1ps
module fpa_pre #(
  parameter int WordBits = fpa_pkg::WordBitsDef,
  parameter int FracBits = fpa_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [fpa_pkg::ActBits-1:0]   action_i,
  input  logic signed [WordBits-1:0]    a_i,
  input  logic signed [WordBits-1:0]    b_i,
  output fpa_pkg::ctrl_t                ctrl_o,
  output logic [WordBits-1:0]           res_o,
  output logic [WordBits-1:0]           ma_o,
  output logic [WordBits-1:0]           mb_o
);
  import fpa_pkg::*;

  ctrl_t               ctrl_d, ctrl_q;
  logic [WordBits-1:0] res_d, res_q, ma_q, mb_q, ma_d, mb_d;
  logic                lt, gt, eq;
  action_e             act;

  assign act = action_e'(action_i);
  assign lt  = a_i < b_i;
  assign gt  = b_i < a_i;
  assign eq  = a_i == b_i;
  assign ma_d = a_i[WordBits-1] ? WordBits'(-a_i) : WordBits'(a_i);
  assign mb_d = b_i[WordBits-1] ? WordBits'(-b_i) : WordBits'(b_i);

  always_comb begin
    ctrl_d.valid = in_valid_i;
    ctrl_d.act   = act;
    ctrl_d.neg   = a_i[WordBits-1] ^ b_i[WordBits-1];
    ctrl_d.truth = 1'b0;
    ctrl_d.dz    = (act == ACT_DIV) && (b_i == '0);
    res_d        = '0;
    case (act)
      ACT_ADD:      res_d = WordBits'(a_i + b_i);
      ACT_SUB:      res_d = WordBits'(a_i - b_i);
      ACT_EQ:       ctrl_d.truth = eq;
      ACT_NE:       ctrl_d.truth = !eq;
      ACT_GE:       ctrl_d.truth = !lt;
      ACT_LE:       ctrl_d.truth = !gt;
      ACT_GT:       ctrl_d.truth = gt;
      ACT_LT:       ctrl_d.truth = lt;
      ACT_MIN:      res_d = lt ? a_i : b_i;
      ACT_MAX:      res_d = gt ? a_i : b_i;
      ACT_INC:      res_d = WordBits'(a_i + WordBits'(1));
      ACT_DEC:      res_d = WordBits'(a_i - WordBits'(1));
      ACT_TO_INT:   res_d = WordBits'(a_i >>> FracBits);
      ACT_FROM_INT: res_d = WordBits'(a_i << FracBits);
      default:      res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ma_q  <= ma_d;
    mb_q  <= mb_d;
  end

  assign ctrl_o = ctrl_q;
  assign res_o  = res_q;
  assign ma_o   = ma_q;
  assign mb_o   = mb_q;
endmodule

/* hdl/fpa_mul.sv */
`timescale 1ns / 1ps
module fpa_mul #(
  parameter int WordBits = fpa_pkg::WordBitsDef,
  parameter int FracBits = fpa_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic [WordBits-1:0] ma_i,
  input  logic [WordBits-1:0] mb_i,
  output logic [WordBits-1:0] q_o
);
  localparam int SumBits = WordBits + FracBits;

  logic [2*WordBits-1:0] prod_q;
  logic [SumBits-1:0]    sum;
  logic [WordBits-1:0]   q_q;

  // round half away from zero on the magnitude
  assign sum = prod_q[SumBits-1:0] + (SumBits'(1) << (FracBits - 1));

  always_ff @(posedge clk_i) begin
    prod_q <= ma_i * mb_i;
    q_q    <= sum[SumBits-1:FracBits];
  end

  assign q_o = q_q;
endmodule

/* hdl/fpa_div_stage.sv */
`timescale 1ns / 1ps
module fpa_div_stage #(
  parameter int WordBits = fpa_pkg::WordBitsDef,
  parameter int FracBits = fpa_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic [WordBits-1:0]          rem_i,
  input  logic [WordBits+FracBits-1:0] n_i,
  input  logic [WordBits-1:0]          q_i,
  input  logic [WordBits-1:0]          d_i,
  output logic [WordBits-1:0]          rem_o,
  output logic [WordBits+FracBits-1:0] n_o,
  output logic [WordBits-1:0]          q_o,
  output logic [WordBits-1:0]          d_o
);
  localparam int NBits = WordBits + FracBits;

  logic [WordBits:0]   trial, diff;
  logic                ge;
  logic [WordBits-1:0] rem_q, q_q, d_q;
  logic [NBits-1:0]    n_q;

  assign trial = {rem_i, n_i[NBits-1]};
  assign ge    = trial >= {1'b0, d_i};
  assign diff  = trial - {1'b0, d_i};

  always_ff @(posedge clk_i) begin
    rem_q <= ge ? diff[WordBits-1:0] : trial[WordBits-1:0];
    q_q   <= {q_i[WordBits-2:0], ge};
    n_q   <= {n_i[NBits-2:0], 1'b0};
    d_q   <= d_i;
  end

  assign rem_o = rem_q;
  assign n_o   = n_q;
  assign q_o   = q_q;
  assign d_o   = d_q;
endmodule

/* hdl/fpa_div.sv */
`timescale 1ns / 1ps
module fpa_div #(
  parameter int WordBits = fpa_pkg::WordBitsDef,
  parameter int FracBits = fpa_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic [WordBits-1:0] ma_i,
  input  logic [WordBits-1:0] mb_i,
  output logic [WordBits-1:0] q_o
);
  localparam int NBits = WordBits + FracBits;

  logic [WordBits-1:0] rem_w [NBits+1];
  logic [NBits-1:0]    n_w   [NBits+1];
  logic [WordBits-1:0] q_w   [NBits+1];
  logic [WordBits-1:0] d_w   [NBits+1];
  logic [WordBits-1:0] q_q;

  assign rem_w[0] = '0;
  assign n_w[0]   = {ma_i, {FracBits{1'b0}}};
  assign q_w[0]   = '0;
  assign d_w[0]   = mb_i;

  for (genvar i = 0; i < NBits; i++) begin : g_stage
    fpa_div_stage #(.WordBits(WordBits), .FracBits(FracBits)) u_stage (
      .clk_i (clk_i),
      .rem_i (rem_w[i]),
      .n_i   (n_w[i]),
      .q_i   (q_w[i]),
      .d_i   (d_w[i]),
      .rem_o (rem_w[i+1]),
      .n_o   (n_w[i+1]),
      .q_o   (q_w[i+1]),
      .d_o   (d_w[i+1])
    );
  end

  // round up when the remainder is at least half the divisor
  always_ff @(posedge clk_i) begin
    q_q <= q_w[NBits] +
           WordBits'({rem_w[NBits], 1'b0} >= {1'b0, d_w[NBits]});
  end

  assign q_o = q_q;
endmodule

/* hdl/fixed_point_q24_8_alu_core.sv */
`timescale 1ns / 1ps
// Results are Q24.8; a request passes the input register, the control side line and the output register to valid_o.
// Throughput: one request per cycle; busy stays low, as the divider is pipelined with one bit per stage.
// The divider pipeline (one stage per dividend bit) sets the latency for every operation.
// Reset (rst_ni low, asynchronous) clears all valid bits; the receiver cannot stall.
module fixed_point_q24_8_alu_core #(
  parameter int WordBits = fpa_pkg::WordBitsDef,
  parameter int FracBits = fpa_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [fpa_pkg::ActBits-1:0] action_i,
  input  logic signed [WordBits-1:0]  operand_a_i,
  input  logic signed [WordBits-1:0]  operand_b_i,
  output logic                        valid_o,
  output logic signed [WordBits-1:0]  result_o,
  output logic                        truth_o,
  output logic                        div_zero_o
);
  import fpa_pkg::*;

  localparam int DivStages = WordBits + FracBits;

  ctrl_t               pre_ctrl;
  logic [WordBits-1:0] pre_res, ma, mb, mul_q, div_q;

  // side lines that keep control and easy results aligned with the divider
  ctrl_t               ctrl_pipe_q [DivStages+1];
  logic [WordBits-1:0] res_pipe_q  [DivStages+1];
  logic [WordBits-1:0] mul_pipe_q  [DivStages-1];

  ctrl_t               ctrl_end;
  logic [WordBits-1:0] result_d, result_q;
  logic                valid_q, truth_q, dz_q;

  // no back-pressure anywhere: accept a request every cycle
  assign busy = 1'b0;

  fpa_pre #(.WordBits(WordBits), .FracBits(FracBits)) u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .action_i   (action_i),
    .a_i        (operand_a_i),
    .b_i        (operand_b_i),
    .ctrl_o     (pre_ctrl),
    .res_o      (pre_res),
    .ma_o       (ma),
    .mb_o       (mb)
  );

  fpa_mul #(.WordBits(WordBits), .FracBits(FracBits)) u_mul (
    .clk_i (clk_i),
    .ma_i  (ma),
    .mb_i  (mb),
    .q_o   (mul_q)
  );

  fpa_div #(.WordBits(WordBits), .FracBits(FracBits)) u_div (
    .clk_i (clk_i),
    .ma_i  (ma),
    .mb_i  (mb),
    .q_o   (div_q)
  );

  // advance control with reset so stale requests never surface
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DivStages; i++) begin
        ctrl_pipe_q[i] <= '0;
      end
    end else begin
      ctrl_pipe_q[0] <= pre_ctrl;
      for (int i = 1; i <= DivStages; i++) begin
        ctrl_pipe_q[i] <= ctrl_pipe_q[i-1];
      end
    end
  end

  // advance payload; no reset needed
  always_ff @(posedge clk_i) begin
    res_pipe_q[0] <= pre_res;
    for (int i = 1; i <= DivStages; i++) begin
      res_pipe_q[i] <= res_pipe_q[i-1];
    end
    mul_pipe_q[0] <= mul_q;
    for (int i = 1; i < DivStages - 1; i++) begin
      mul_pipe_q[i] <= mul_pipe_q[i-1];
    end
  end

  assign ctrl_end = ctrl_pipe_q[DivStages];

  // apply the sign to product and quotient, drop the quotient on a zero divisor
  always_comb begin
    case (ctrl_end.act)
      ACT_MUL: result_d = ctrl_end.neg ? WordBits'(-mul_pipe_q[DivStages-2])
                                       : mul_pipe_q[DivStages-2];
      ACT_DIV: begin
        if (ctrl_end.dz) begin
          result_d = '0;
        end else begin
          result_d = ctrl_end.neg ? WordBits'(-div_q) : div_q;
        end
      end
      default: result_d = res_pipe_q[DivStages];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      truth_q <= 1'b0;
      dz_q    <= 1'b0;
    end else begin
      valid_q <= ctrl_end.valid;
      truth_q <= ctrl_end.valid && ctrl_end.truth;
      dz_q    <= ctrl_end.valid && ctrl_end.dz;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o    = valid_q;
  assign result_o   = result_q;
  assign truth_o    = truth_q;
  assign div_zero_o = dz_q;

`ifndef SYNTHESIS
  a_flags_need_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> (!truth_o && !div_zero_o))
    else $error("flag raised without a result");
  a_dz_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_zero_o |-> (result_o == '0))
    else $error("divide by zero gave nonzero result");
  a_truth_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    truth_o |-> (result_o == '0))
    else $error("comparison gave nonzero result");
`endif
endmodule

/* sim/fixed_point_q24_8_alu_core_tb.sv */
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_core_tb;
  import fpa_pkg::*;

  localparam int W = 32;
  localparam int F = 8;
  localparam int LATENCY = W + F + 2;
  localparam int IDLE_LIMIT = 4000;
  localparam int NUM_RANDOM = 2000;

  typedef struct {
    logic signed [W-1:0] result;
    logic                truth;
    logic                dz;
  } alu_out_t;

  // Scoreboard: predicts one result per accepted request, checks in order.
  class alu_scoreboard;
    alu_out_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Round half away from zero: add half an LSB to the magnitude, then shift.
    function automatic logic [W-1:0] predict_mul(logic signed [W-1:0] a, logic signed [W-1:0] b);
      logic signed [2*W+1:0] p;
      logic [2*W+1:0] m;
      logic [2*W+1:0] q;
      p = $signed({{(W+2){a[W-1]}}, a}) * $signed({{(W+2){b[W-1]}}, b});
      m = p[2*W+1] ? -p : p;
      q = (m + (1 << (F - 1))) >> F;
      predict_mul = p[2*W+1] ? -q[W-1:0] : q[W-1:0];
    endfunction

    function automatic logic [W-1:0] predict_div(logic signed [W-1:0] a, logic signed [W-1:0] b);
      logic [W+F:0] n;
      logic [W:0] d;
      logic [W+F:0] q;
      logic [W+F:0] r;
      logic neg;
      neg = a[W-1] ^ b[W-1];
      // take the magnitude at 33 bits before widening the dividend
      n = {(a[W-1] ? -{a[W-1], a} : {1'b0, a}), {F{1'b0}}};
      d = b[W-1] ? -{b[W-1], b} : {1'b0, b};
      q = n / d;
      r = n % d;
      if (r >= d - r) q = q + 1;
      predict_div = neg ? -q[W-1:0] : q[W-1:0];
    endfunction

    function void note_request(action_e act, logic signed [W-1:0] a, logic signed [W-1:0] b);
      alu_out_t o;
      o.result = '0;
      o.truth = 1'b0;
      o.dz = 1'b0;
      case (act)
        ACT_ADD: o.result = a + b;
        ACT_SUB: o.result = a - b;
        ACT_MUL: o.result = predict_mul(a, b);
        ACT_DIV: begin
          if (b == 0) o.dz = 1'b1;
          else o.result = predict_div(a, b);
        end
        ACT_EQ: o.truth = (a == b);
        ACT_NE: o.truth = (a != b);
        ACT_GE: o.truth = (a >= b);
        ACT_LE: o.truth = (a <= b);
        ACT_GT: o.truth = (a > b);
        ACT_LT: o.truth = (a < b);
        ACT_MIN: o.result = (a < b) ? a : b;
        ACT_MAX: o.result = (b < a) ? a : b;
        ACT_INC: o.result = a + 1;
        ACT_DEC: o.result = a - 1;
        ACT_TO_INT: o.result = a >>> F;
        default: o.result = a << F;
      endcase
      pending.push_back(o);
    endfunction

    function void check_result(logic signed [W-1:0] res, logic truth, logic dz);
      alu_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h truth %b dz %b", $time, res, truth, dz);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (res !== e.result) begin
        $display("%0t: result expected %h actual %h", $time, e.result, res);
        errors++;
      end
      if (truth !== e.truth) begin
        $display("%0t: truth expected %b actual %b", $time, e.truth, truth);
        errors++;
      end
      if (dz !== e.dz) begin
        $display("%0t: div_zero expected %b actual %b", $time, e.dz, dz);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ActBits-1:0] action_i = '0;
  logic signed [W-1:0] operand_a_i = '0;
  logic signed [W-1:0] operand_b_i = '0;
  logic valid_o;
  logic signed [W-1:0] result_o;
  logic truth_o;
  logic div_zero_o;

  alu_scoreboard sb = new();
  int idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  fixed_point_q24_8_alu_core DUT (
    .clk_i, .rst_ni, .start, .busy, .action_i, .operand_a_i, .operand_b_i,
    .valid_o, .result_o, .truth_o, .div_zero_o
  );

  // Sample outputs at the edge; check results and count idle cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) sb.check_result(result_o, truth_o, div_zero_o);
      if (valid_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("fixed_point_q24_8_alu_core test failed");
        $finish;
      end
    end
  end

  // Present one request, hold it until accepted, note it in the scoreboard.
  task automatic send_request(action_e act, logic signed [W-1:0] a, logic signed [W-1:0] b);
    start <= 1'b1;
    action_i <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy);
    sb.note_request(act, a, b);
  endtask

  // Drop start for a random gap: mostly none or short, sometimes long.
  task automatic idle_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: rand_operand = $urandom;
      1: rand_operand = $signed($urandom_range(0, 4095)) - 2048;
      2: rand_operand = {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'(0)} | 32'($urandom_range(0, 65535));
      3: rand_operand = 32'h7fffffff - $urandom_range(0, 3);
      4: rand_operand = 32'h80000000 + $urandom_range(0, 3);
      default: rand_operand = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  initial begin
    logic signed [W-1:0] mx;
    logic signed [W-1:0] mn;
    logic signed [W-1:0] b;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every operation, divide by zero, wrap, ties.
    send_request(ACT_ADD, mx, 32'sd1);
    send_request(ACT_SUB, mn, 32'sd1);
    send_request(ACT_MUL, mx, mx);
    send_request(ACT_MUL, mn, mn);
    send_request(ACT_MUL, 32'sh180, -32'sh080);
    send_request(ACT_MUL, 32'sd1, 32'sd128);
    send_request(ACT_DIV, mx, 32'sd0);
    send_request(ACT_DIV, mn, -32'sd1);
    send_request(ACT_DIV, 32'sd1, 32'sd512);
    send_request(ACT_DIV, -32'sd300, 32'sd7);
    send_request(ACT_EQ, mn, mn);
    send_request(ACT_NE, mn, mx);
    send_request(ACT_GE, mn, mx);
    send_request(ACT_LE, mn, mx);
    send_request(ACT_GT, mx, mn);
    send_request(ACT_LT, mx, mx);
    send_request(ACT_MIN, 32'sd5, 32'sd5);
    send_request(ACT_MAX, mn, mx);
    send_request(ACT_INC, mx, mn);
    send_request(ACT_DEC, mn, mx);
    send_request(ACT_TO_INT, -32'sd1, 32'sd0);
    send_request(ACT_TO_INT, mx, 32'sd0);
    send_request(ACT_FROM_INT, mx, 32'sd0);
    send_request(ACT_FROM_INT, mn, -32'sd1);

    // Random: any operation, operands biased toward edges and small values.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      idle_gap();
      b = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_operand();
      send_request(action_e'($urandom_range(0, 15)), rand_operand(), b);
    end
    start <= 1'b0;

    // Drain: wait for every result, then let the clock run on with start low so a stray result is still seen.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (sb.errors == 0) $display("fixed_point_q24_8_alu_core test passed");
    else $display("fixed_point_q24_8_alu_core test failed");
    $finish;
  end
endmodule
